// ===== hw/rtl/pwmc_pkg.sv =====
// shared types, constants and register codes of the pwm period and compare calculator
package pwmc_pkg;

	// default timer input clock in hertz
	localparam int unsigned CORE_CLOCK_HZ_DEF = 168000000;

	// field widths
	localparam int unsigned DUTY_W   = 16;
	localparam int unsigned MAG_W    = 17;
	localparam int unsigned PRESC_W  = 10;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// divisor freq * (prescaler + 1) * scaler stays below 2^17
	localparam int unsigned DIV_W = 17;

	// frequency band limits in hertz
	localparam logic [FREQ_W-1:0] BAND_HI  = 16'd3000;
	localparam logic [FREQ_W-1:0] BAND_MID = 16'd300;
	localparam logic [FREQ_W-1:0] BAND_LO  = 16'd30;
	localparam logic [FREQ_W-1:0] BAND_MIN = 16'd3;

	// prescaler values of the bands
	localparam logic [PRESC_W-1:0] PRESC_DIV1    = 10'd0;
	localparam logic [PRESC_W-1:0] PRESC_DIV10   = 10'd9;
	localparam logic [PRESC_W-1:0] PRESC_DIV100  = 10'd99;
	localparam logic [PRESC_W-1:0] PRESC_DIV1000 = 10'd999;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_FREQ  = 2'd0,
		CFG_TIMER_ADV = 2'd1,
		CFG_DIR_EN    = 2'd2,
		CFG_CHAN      = 2'd3
	} cfg_idx_t;

	// decoded configuration handed to the datapath
	typedef struct packed {
		logic [PRESC_W-1:0] prescaler;
		logic [DIV_W-1:0]   divisor;
		logic               clamped;
		logic               dir_en;
		logic               chan;
	} cfg_t;

	// item data travelling along the divider cells
	typedef struct packed {
		logic              vld;
		logic [DUTY_W-1:0] duty;
	} cell_tag_t;

	// result item payload
	typedef struct packed {
		logic [PRESC_W-1:0]  prescaler;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] compare;
		logic                compare_valid;
		logic                dir_level;
		logic                dir_active;
		logic                freq_clamped;
	} result_t;

endpackage

// ===== hw/rtl/pwmc_cmd_if.sv =====
// duty command channel
interface pwmc_cmd_if;
	logic                                valid;
	logic                                ready;
	logic signed [pwmc_pkg::DUTY_W-1:0] duty;

	modport source (output valid, output duty, input ready);
	modport sink   (input valid, input duty, output ready);
endinterface

// ===== hw/rtl/pwmc_res_if.sv =====
// timer settings result channel
interface pwmc_res_if;
	logic                 valid;
	logic                 ready;
	pwmc_pkg::result_t    res;

	modport source (output valid, output res, input ready);
	modport sink   (input valid, input res, output ready);
endinterface

// ===== hw/rtl/pwmc_cfg_regs.sv =====
// configuration registers and frequency band decode
module pwmc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pwmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pwmc_pkg::CFG_W-1:0]        cfg_wdata,
	output pwmc_pkg::cfg_t                     cfg
);

	logic [pwmc_pkg::FREQ_W-1:0] freq_q;
	logic                        timer_adv_q;
	logic                        dir_en_q;
	logic                        chan_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= '0;
			timer_adv_q <= 1'b0;
			dir_en_q    <= 1'b0;
			chan_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (pwmc_pkg::cfg_idx_t'(cfg_idx))
				pwmc_pkg::CFG_PWM_FREQ:  freq_q      <= cfg_wdata[pwmc_pkg::FREQ_W-1:0];
				pwmc_pkg::CFG_TIMER_ADV: timer_adv_q <= cfg_wdata[0];
				pwmc_pkg::CFG_DIR_EN:    dir_en_q    <= cfg_wdata[0];
				pwmc_pkg::CFG_CHAN:      chan_q      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	logic [pwmc_pkg::DIV_W-1:0] freq_ext;
	logic [pwmc_pkg::DIV_W-1:0] band_div;

	// band select: prescaler and freq * (prescaler + 1)
	always_comb begin
		freq_ext    = pwmc_pkg::DIV_W'(freq_q);
		cfg.clamped = 1'b0;
		priority if (freq_q > pwmc_pkg::BAND_HI) begin
			cfg.prescaler = pwmc_pkg::PRESC_DIV1;
			band_div      = freq_ext;
		end else if (freq_q > pwmc_pkg::BAND_MID) begin
			cfg.prescaler = pwmc_pkg::PRESC_DIV10;
			band_div      = freq_ext * pwmc_pkg::DIV_W'(10);
		end else if (freq_q > pwmc_pkg::BAND_LO) begin
			cfg.prescaler = pwmc_pkg::PRESC_DIV100;
			band_div      = freq_ext * pwmc_pkg::DIV_W'(100);
		end else if (freq_q > pwmc_pkg::BAND_MIN) begin
			cfg.prescaler = pwmc_pkg::PRESC_DIV1000;
			band_div      = freq_ext * pwmc_pkg::DIV_W'(1000);
		end else begin
			// low frequency runs as 3 Hz
			cfg.prescaler = pwmc_pkg::PRESC_DIV1000;
			band_div      = pwmc_pkg::DIV_W'(3000);
			cfg.clamped   = 1'b1;
		end
		// half-clock timer doubles the divisor
		cfg.divisor = timer_adv_q ? band_div : {band_div[pwmc_pkg::DIV_W-2:0], 1'b0};
		cfg.dir_en  = dir_en_q;
		cfg.chan    = chan_q;
	end

endmodule

// ===== hw/rtl/pwmc_div_cell.sv =====
// one restoring division cell: produces one quotient bit per item
module pwmc_div_cell #(
	parameter int unsigned CLK_HZ  = pwmc_pkg::CORE_CLOCK_HZ_DEF,
	parameter int unsigned CLK_W   = 28,
	parameter int unsigned BIT_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [pwmc_pkg::DIV_W-1:0]    divisor,
	input  logic [pwmc_pkg::DIV_W-1:0]    rem_i,
	input  logic [CLK_W-1:0]              quo_i,
	input  pwmc_pkg::cell_tag_t           tag_i,
	output logic [pwmc_pkg::DIV_W-1:0]    rem_q,
	output logic [CLK_W-1:0]              quo_q,
	output pwmc_pkg::cell_tag_t           tag_q
);

	localparam logic [CLK_W-1:0] DIVIDEND = CLK_W'(CLK_HZ);
	localparam logic             DIV_BIT  = DIVIDEND[BIT_IDX];

	logic [pwmc_pkg::DIV_W:0] trial;
	logic [pwmc_pkg::DIV_W:0] diff;
	logic                     fits;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_i, DIV_BIT};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// item valid flag and duty hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_i;
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? diff[pwmc_pkg::DIV_W-1:0] : trial[pwmc_pkg::DIV_W-1:0];
			quo_q <= {quo_i[CLK_W-2:0], fits};
		end
	end

endmodule

// ===== hw/rtl/pwm_period_and_compare_calc.sv =====
// pwm period and compare calculator top level
// an item passes the divider cells, one quotient bit each, then s1 and the result register
// throughput: one item per cycle unless res stalls; the period divider is a row of cells
// a stalled result holds the whole pipeline; the cells advance together
// reset: config, valid and tag registers clear to 0, pipeline empties; no clearing pass
module pwm_period_and_compare_calc #(
	parameter int unsigned CORE_CLOCK_HZ = pwmc_pkg::CORE_CLOCK_HZ_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwmc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pwmc_pkg::CFG_W-1:0]       cfg_wdata,
	pwmc_cmd_if.sink                          cmd,
	pwmc_res_if.source                        res
);

	localparam int unsigned CLK_W = $clog2(CORE_CLOCK_HZ + 1);
	localparam logic [CLK_W-1:0] SAT_LIM = CLK_W'(65536);
	localparam int unsigned PROD_W = pwmc_pkg::MAG_W + pwmc_pkg::PERIOD_W;

	pwmc_pkg::cfg_t cfg;

	// configuration registers
	pwmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline advances whenever the output register is free or being taken
	logic en;
	logic vld_q;
	assign en        = !vld_q || res.ready;
	assign cmd.ready = en;

	// divider cell chain
	logic [pwmc_pkg::DIV_W-1:0] rem_c [0:CLK_W];
	logic [CLK_W-1:0]           quo_c [0:CLK_W];
	pwmc_pkg::cell_tag_t        tag_c [0:CLK_W];

	assign rem_c[0] = '0;
	assign quo_c[0] = '0;
	assign tag_c[0] = {cmd.valid, cmd.duty};

	for (genvar k = 0; k < CLK_W; k++) begin : g_cell
		pwmc_div_cell #(
			.CLK_HZ  (CORE_CLOCK_HZ),
			.CLK_W   (CLK_W),
			.BIT_IDX (CLK_W - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (cfg.divisor),
			.rem_i   (rem_c[k]),
			.quo_i   (quo_c[k]),
			.tag_i   (tag_c[k]),
			.rem_q   (rem_c[k+1]),
			.quo_q   (quo_c[k+1]),
			.tag_q   (tag_c[k+1])
		);
	end

	// period saturation and duty magnitude
	logic [CLK_W-1:0]              quo_end;
	logic [pwmc_pkg::DUTY_W-1:0]   duty_end;
	logic [pwmc_pkg::PERIOD_W-1:0] period_d;
	logic [pwmc_pkg::MAG_W-1:0]    mag_d;

	always_comb begin
		quo_end  = quo_c[CLK_W];
		duty_end = tag_c[CLK_W].duty;
		priority if (quo_end == '0) begin
			period_d = '0;
		end else if (quo_end > SAT_LIM) begin
			period_d = '1;
		end else begin
			period_d = pwmc_pkg::PERIOD_W'(quo_end - CLK_W'(1));
		end
		mag_d = duty_end[pwmc_pkg::DUTY_W-1]
			? pwmc_pkg::MAG_W'(0) - {1'b1, duty_end}
			: {1'b0, duty_end};
	end

	logic                          vld_s1;
	logic [pwmc_pkg::PERIOD_W-1:0] period_s1;
	logic [pwmc_pkg::MAG_W-1:0]    mag_s1;
	logic                          neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tag_c[CLK_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			period_s1 <= period_d;
			mag_s1    <= mag_d;
			neg_s1    <= duty_end[pwmc_pkg::DUTY_W-1];
		end
	end

	// compare multiply and result register
	logic [PROD_W-1:0] prod;
	pwmc_pkg::result_t res_d;
	pwmc_pkg::result_t res_q;

	always_comb begin
		prod                = PROD_W'(mag_s1) * PROD_W'(period_s1);
		res_d.prescaler     = cfg.prescaler;
		res_d.period        = period_s1;
		res_d.compare       = cfg.chan ? prod[15 +: pwmc_pkg::PERIOD_W] : '0;
		res_d.compare_valid = cfg.chan;
		res_d.dir_level     = cfg.dir_en && !neg_s1;
		res_d.dir_active    = cfg.dir_en;
		res_d.freq_clamped  = cfg.clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign res.valid = vld_q;
	assign res.res   = res_q;

endmodule
